// ===== hdl/rmt_pkg.sv =====
// Shared constants, codes and the request record for the recursive mutex table.
package rmt_pkg;

  localparam int NUM_MUTEXES = 16;
  localparam int NUM_TASKS   = 16;

  localparam int IDX_IN_W = 4;
  localparam int TASK_W   = 4;
  localparam int PRIO_W   = 8;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;

  localparam int MIDX_W  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int SLOT_W  = $clog2(NUM_TASKS);
  localparam int PTR_W   = $clog2(2 * NUM_TASKS);
  localparam int LVL_W   = PTR_W + 1;
  localparam int WADDR_W = $clog2(NUM_MUTEXES * NUM_TASKS);
  localparam int CNT_W   = 7;
  localparam int CNT_MAX = 127;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FIFO    = 3'd1;
  localparam logic [STAT_W-1:0] ST_INHERIT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FAULT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOFREE  = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [MIDX_W-1:0] idx;
    logic [TASK_W-1:0] task_id;
    logic              inherit;
    logic              bad_idx;
  } rmt_item_t;

endpackage

// ===== hdl/recursive_mutex_table_core.sv =====
// Top level of the recursive mutex table: request intake plus execute unit.
//
//  channel   ports                      handshake
//  request   start, busy, in_*          transfer when start && !busy
//  result    out_valid, out_*           one-cycle strobe, always taken
//
// The execute unit reads the head waiter of the addressed entry from the waiter store as it
// pops a request; in its execute state it reads the entry, writes it back and loads the result.
// A request taken into an empty intake queue is registered in a queue slot, then in the execute
// registers, then in the result registers, which raise its result strobe.
// Up to two requests wait in the intake queue; busy is high while it is full.
// Reset (synchronous, active low) clears all entries at once; no clearing pass.
// Results are never held back by the receiver.
module recursive_mutex_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rmt_pkg::REQ_W-1:0]     in_req_type,
  input  logic [rmt_pkg::IDX_IN_W-1:0]  in_mutex_index,
  input  logic [rmt_pkg::TASK_W-1:0]    in_task_id,
  input  logic [rmt_pkg::PRIO_W-1:0]    in_requester_priority,
  input  logic [rmt_pkg::PRIO_W-1:0]    in_owner_priority,
  output logic                          out_valid,
  output logic [rmt_pkg::STAT_W-1:0]    out_status,
  output logic [rmt_pkg::IDX_IN_W-1:0]  out_created_index,
  output logic                          out_wake_valid,
  output logic [rmt_pkg::TASK_W-1:0]    out_wake_task,
  output logic                          out_restore_priority
);
  import rmt_pkg::*;

  logic      q_valid;
  rmt_item_t q_item;
  logic      pop;

  rmt_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_req_type           (in_req_type),
    .in_mutex_index        (in_mutex_index),
    .in_task_id            (in_task_id),
    .in_requester_priority (in_requester_priority),
    .in_owner_priority     (in_owner_priority),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .pop                   (pop)
  );

  rmt_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_created_index    (out_created_index),
    .out_wake_valid       (out_wake_valid),
    .out_wake_task        (out_wake_task),
    .out_restore_priority (out_restore_priority)
  );

endmodule

// ===== hdl/rmt_front.sv =====
// Request intake: classify each request and hold it in a short queue for the execute unit.
module rmt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rmt_pkg::REQ_W-1:0]        in_req_type,
  input  logic [rmt_pkg::IDX_IN_W-1:0]     in_mutex_index,
  input  logic [rmt_pkg::TASK_W-1:0]       in_task_id,
  input  logic [rmt_pkg::PRIO_W-1:0]       in_requester_priority,
  input  logic [rmt_pkg::PRIO_W-1:0]       in_owner_priority,
  output logic                             q_valid,
  output rmt_pkg::rmt_item_t               q_item,
  input  logic                             pop
);
  import rmt_pkg::*;

  rmt_item_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  rmt_item_t           item_in;
  logic                push, do_pop;

  always_comb begin
    item_in.req     = in_req_type;
    item_in.idx     = MIDX_W'(in_mutex_index);
    item_in.task_id = in_task_id;
    // a waiter that is more urgent than the owner asks for inheritance
    item_in.inherit = (in_requester_priority < in_owner_priority);
    item_in.bad_idx = (in_req_type != REQ_CREATE) &&
                      ({28'd0, in_mutex_index} >= 32'(NUM_MUTEXES));
  end

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign do_pop  = pop && q_valid;
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("request queue over depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !pop |=> busy)
    else $error("queue drained without a pop");

endmodule

// ===== hdl/rmt_back.sv =====
// Execute unit: read-modify-write of one mutex entry and its waiter store per request.
module rmt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rmt_pkg::rmt_item_t            q_item,
  output logic                          pop,
  output logic                          out_valid,
  output logic [rmt_pkg::STAT_W-1:0]    out_status,
  output logic [rmt_pkg::IDX_IN_W-1:0]  out_created_index,
  output logic                          out_wake_valid,
  output logic [rmt_pkg::TASK_W-1:0]    out_wake_task,
  output logic                          out_restore_priority
);
  import rmt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    if (p >= PTR_W'(NUM_TASKS)) begin
      slot_of = SLOT_W'(p - PTR_W'(NUM_TASKS));
    end else begin
      slot_of = SLOT_W'(p);
    end
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(2 * NUM_TASKS - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  function automatic logic [LVL_W-1:0] level_of(input logic [PTR_W-1:0] h,
                                                input logic [PTR_W-1:0] t);
    if (t >= h) begin
      level_of = {1'b0, t} - {1'b0, h};
    end else begin
      level_of = {1'b0, t} + LVL_W'(2 * NUM_TASKS) - {1'b0, h};
    end
  endfunction

  function automatic logic [WADDR_W-1:0] waddr_of(input logic [MIDX_W-1:0] m,
                                                  input logic [SLOT_W-1:0] s);
    waddr_of = WADDR_W'(m) * WADDR_W'(NUM_TASKS) + WADDR_W'(s);
  endfunction

  logic                state_r, state_nxt;
  rmt_item_t           item_r;

  logic                in_use_r [NUM_MUTEXES];
  logic [CNT_W-1:0]    cnt_r    [NUM_MUTEXES];
  logic [TASK_W-1:0]   own_r    [NUM_MUTEXES];
  logic                ownv_r   [NUM_MUTEXES];
  logic [PTR_W-1:0]    head_r   [NUM_MUTEXES];
  logic [PTR_W-1:0]    tail_r   [NUM_MUTEXES];

  logic [TASK_W-1:0]   wait_mem [NUM_MUTEXES * NUM_TASKS];
  logic [TASK_W-1:0]   rd_data_r;
  logic [WADDR_W-1:0]  raddr, waddr;
  logic                mem_we;

  logic                free_found;
  logic [MIDX_W-1:0]   free_idx;

  logic [MIDX_W-1:0]   m;
  logic                cur_use, cur_ownv;
  logic [CNT_W-1:0]    cur_cnt;
  logic [TASK_W-1:0]   cur_own;
  logic [PTR_W-1:0]    cur_head, cur_tail;
  logic [LVL_W-1:0]    cur_lvl;

  logic                upd;
  logic [MIDX_W-1:0]   tgt;
  logic                ent_use_nxt, ent_ownv_nxt;
  logic [CNT_W-1:0]    ent_cnt_nxt;
  logic [TASK_W-1:0]   ent_own_nxt;
  logic [PTR_W-1:0]    ent_head_nxt, ent_tail_nxt;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_IN_W-1:0] out_created_r, out_created_nxt;
  logic                out_wake_valid_r, out_wake_valid_nxt;
  logic [TASK_W-1:0]   out_wake_task_r, out_wake_task_nxt;
  logic                out_restore_r, out_restore_nxt;

  assign pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = q_valid ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // lowest free entry for create
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_MUTEXES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = MIDX_W'(i);
      end
    end
  end

  // fetch the head waiter while the request is popped
  assign raddr = waddr_of(q_item.idx, slot_of(head_r[q_item.idx]));

  always_comb begin
    m        = item_r.idx;
    cur_use  = in_use_r[m];
    cur_cnt  = cnt_r[m];
    cur_own  = own_r[m];
    cur_ownv = ownv_r[m];
    cur_head = head_r[m];
    cur_tail = tail_r[m];
    cur_lvl  = level_of(cur_head, cur_tail);
  end

  always_comb begin
    upd                = 1'b0;
    tgt                = m;
    ent_use_nxt        = cur_use;
    ent_cnt_nxt        = cur_cnt;
    ent_own_nxt        = cur_own;
    ent_ownv_nxt       = cur_ownv;
    ent_head_nxt       = cur_head;
    ent_tail_nxt       = cur_tail;
    mem_we             = 1'b0;
    waddr              = waddr_of(m, slot_of(cur_tail));
    out_status_nxt     = ST_FAULT;
    out_created_nxt    = '0;
    out_wake_valid_nxt = 1'b0;
    out_wake_task_nxt  = '0;
    out_restore_nxt    = 1'b0;

    if (item_r.req == REQ_CREATE) begin
      out_status_nxt = ST_NOFREE;
      if (free_found) begin
        upd             = 1'b1;
        tgt             = free_idx;
        ent_use_nxt     = 1'b1;
        ent_cnt_nxt     = '0;
        ent_own_nxt     = '0;
        ent_ownv_nxt    = 1'b0;
        ent_head_nxt    = '0;
        ent_tail_nxt    = '0;
        out_created_nxt = IDX_IN_W'(free_idx);
        out_status_nxt  = ST_OK;
      end
    end else if (!item_r.bad_idx && cur_use) begin
      unique case (item_r.req)
        REQ_ACQUIRE: begin
          if (cur_cnt == '0) begin
            upd            = 1'b1;
            ent_cnt_nxt    = CNT_W'(1);
            ent_own_nxt    = item_r.task_id;
            ent_ownv_nxt   = 1'b1;
            out_status_nxt = ST_OK;
          end else if (cur_ownv && cur_own == item_r.task_id) begin
            if (cur_cnt < CNT_W'(CNT_MAX)) begin
              upd            = 1'b1;
              ent_cnt_nxt    = cur_cnt + CNT_W'(1);
              out_status_nxt = ST_OK;
            end
          end else if (cur_lvl < LVL_W'(NUM_TASKS)) begin
            upd            = 1'b1;
            mem_we         = 1'b1;
            ent_tail_nxt   = ptr_inc(cur_tail);
            out_status_nxt = item_r.inherit ? ST_INHERIT : ST_FIFO;
          end
        end
        REQ_RELEASE: begin
          if (cur_ownv && cur_own == item_r.task_id && cur_cnt != '0) begin
            upd            = 1'b1;
            ent_cnt_nxt    = cur_cnt - CNT_W'(1);
            out_status_nxt = ST_OK;
            if (cur_cnt == CNT_W'(1)) begin
              out_restore_nxt = 1'b1;
              if (cur_lvl != '0) begin
                // hand ownership to the head waiter
                ent_head_nxt       = ptr_inc(cur_head);
                ent_own_nxt        = rd_data_r;
                ent_ownv_nxt       = 1'b1;
                ent_cnt_nxt        = CNT_W'(1);
                out_wake_valid_nxt = 1'b1;
                out_wake_task_nxt  = rd_data_r;
              end else begin
                ent_own_nxt  = '0;
                ent_ownv_nxt = 1'b0;
                ent_head_nxt = '0;
                ent_tail_nxt = '0;
              end
            end
          end
        end
        REQ_DESTROY: begin
          if (cur_cnt == '0) begin
            upd            = 1'b1;
            ent_use_nxt    = 1'b0;
            ent_own_nxt    = '0;
            ent_ownv_nxt   = 1'b0;
            ent_head_nxt   = '0;
            ent_tail_nxt   = '0;
            out_status_nxt = ST_OK;
          end
        end
        default: begin
          out_status_nxt = ST_FAULT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        in_use_r[i] <= 1'b0;
        cnt_r[i]    <= '0;
        own_r[i]    <= '0;
        ownv_r[i]   <= 1'b0;
        head_r[i]   <= '0;
        tail_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
      if (state_r == S_EXEC && upd) begin
        in_use_r[tgt] <= ent_use_nxt;
        cnt_r[tgt]    <= ent_cnt_nxt;
        own_r[tgt]    <= ent_own_nxt;
        ownv_r[tgt]   <= ent_ownv_nxt;
        head_r[tgt]   <= ent_head_nxt;
        tail_r[tgt]   <= ent_tail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r    <= q_item;
      rd_data_r <= wait_mem[raddr];
    end
    if (state_r == S_EXEC && mem_we) begin
      wait_mem[waddr] <= item_r.task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_status_r     <= out_status_nxt;
      out_created_r    <= out_created_nxt;
      out_wake_valid_r <= out_wake_valid_nxt;
      out_wake_task_r  <= out_wake_task_nxt;
      out_restore_r    <= out_restore_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_created_index    = out_created_r;
  assign out_wake_valid       = out_wake_valid_r;
  assign out_wake_task        = out_wake_task_r;
  assign out_restore_priority = out_restore_r;

  a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> out_valid_r)
    else $error("executed request gave no result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe outside the idle slot");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FAULT |->
      !out_wake_valid_r && !out_restore_r && out_created_r == '0 && out_wake_task_r == '0)
    else $error("fault result carries side fields");

  a_wake_full_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wake_valid_r |-> out_restore_r && out_status_r == ST_OK)
    else $error("wake without a full release");

endmodule

// ===== bench/recursive_mutex_table_core_tb.sv =====
// Self-checking bench for the recursive mutex table: directed corners, then random traffic.
`timescale 1ns / 100ps

module recursive_mutex_table_core_tb;
  import rmt_pkg::*;

  localparam int TARGET_ITEMS = 1300;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [IDX_IN_W-1:0] created_index;
    logic                wake_valid;
    logic [TASK_W-1:0]   wake_task;
    logic                restore_priority;
  } lock_outcome_t;

  // Shadow copy of the mutex table plus the list of outcomes still in flight.
  class mutex_scoreboard;
    bit              in_use     [NUM_MUTEXES];
    bit [CNT_W-1:0]  hold_count [NUM_MUTEXES];
    bit [TASK_W-1:0] owner      [NUM_MUTEXES];
    bit              owned      [NUM_MUTEXES];
    bit [PTR_W-1:0]  q_head     [NUM_MUTEXES];
    bit [PTR_W-1:0]  q_tail     [NUM_MUTEXES];
    bit [TASK_W-1:0] waiters    [NUM_MUTEXES * NUM_TASKS];
    lock_outcome_t   pending_outcomes [$];
    int              errors;
    int              checked;
    int              wakes;
    int              status_seen [5];

    function void clear_entry(int m);
      hold_count[m] = '0;
      owner[m]      = '0;
      owned[m]      = 1'b0;
      q_head[m]     = '0;
      q_tail[m]     = '0;
    endfunction

    // Predict the outcome of one accepted request and advance the shadow table.
    function void record_request(logic [REQ_W-1:0] req, logic [IDX_IN_W-1:0] m,
                                 logic [TASK_W-1:0] tid, logic [PRIO_W-1:0] rprio,
                                 logic [PRIO_W-1:0] oprio);
      lock_outcome_t   o;
      bit [PTR_W-1:0]  lvl;
      bit [TASK_W-1:0] nxt;
      bit              found;
      int              i;
      o        = '0;
      o.status = ST_FAULT;
      lvl      = q_tail[m] - q_head[m];
      if (req == REQ_CREATE) begin
        o.status = ST_NOFREE;
        found    = 1'b0;
        for (i = 0; i < NUM_MUTEXES; i++) begin
          if (!found && !in_use[i]) begin
            found     = 1'b1;
            in_use[i] = 1'b1;
            clear_entry(i);
            o.created_index = i[IDX_IN_W-1:0];
            o.status        = ST_OK;
          end
        end
      end else if (m < NUM_MUTEXES && in_use[m]) begin
        case (req)
          REQ_ACQUIRE: begin
            if (hold_count[m] == 0) begin
              hold_count[m] = CNT_W'(1);
              owner[m]      = tid;
              owned[m]      = 1'b1;
              o.status      = ST_OK;
            end else if (owned[m] && owner[m] == tid) begin
              if (hold_count[m] < CNT_MAX) begin
                hold_count[m] = hold_count[m] + 1'b1;
                o.status      = ST_OK;
              end
            end else if (lvl < NUM_TASKS) begin
              waiters[m * NUM_TASKS + q_tail[m][SLOT_W-1:0]] = tid;
              q_tail[m] = q_tail[m] + 1'b1;
              o.status  = (rprio < oprio) ? ST_INHERIT : ST_FIFO;
            end
          end
          REQ_RELEASE: begin
            if (owned[m] && owner[m] == tid && hold_count[m] != 0) begin
              hold_count[m] = hold_count[m] - 1'b1;
              o.status      = ST_OK;
              if (hold_count[m] == 0) begin
                o.restore_priority = 1'b1;
                if (lvl != 0) begin
                  // hand ownership straight to the oldest waiter
                  nxt           = waiters[m * NUM_TASKS + q_head[m][SLOT_W-1:0]];
                  q_head[m]     = q_head[m] + 1'b1;
                  owner[m]      = nxt;
                  owned[m]      = 1'b1;
                  hold_count[m] = CNT_W'(1);
                  o.wake_valid  = 1'b1;
                  o.wake_task   = nxt;
                end else begin
                  clear_entry(m);
                end
              end
            end
          end
          default: begin
            if (hold_count[m] == 0) begin
              in_use[m] = 1'b0;
              clear_entry(m);
              o.status = ST_OK;
            end
          end
        endcase
      end
      pending_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(lock_outcome_t got);
      lock_outcome_t exp_o;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        errors++;
        return;
      end
      exp_o = pending_outcomes.pop_front();
      checked++;
      if (exp_o.status <= ST_NOFREE) status_seen[exp_o.status]++;
      if (exp_o.wake_valid) wakes++;
      compare_field("status", exp_o.status, got.status);
      compare_field("created_index", exp_o.created_index, got.created_index);
      compare_field("wake_valid", exp_o.wake_valid, got.wake_valid);
      compare_field("wake_task", exp_o.wake_task, got.wake_task);
      compare_field("restore_priority", exp_o.restore_priority, got.restore_priority);
    endfunction
  endclass

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [REQ_W-1:0]    in_req_type           = '0;
  logic [IDX_IN_W-1:0] in_mutex_index        = '0;
  logic [TASK_W-1:0]   in_task_id            = '0;
  logic [PRIO_W-1:0]   in_requester_priority = '0;
  logic [PRIO_W-1:0]   in_owner_priority     = '0;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [IDX_IN_W-1:0] out_created_index;
  logic                out_wake_valid;
  logic [TASK_W-1:0]   out_wake_task;
  logic                out_restore_priority;

  mutex_scoreboard sb;
  int              items_sent;
  bit              steady;

  recursive_mutex_table_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_mutex_index       (in_mutex_index),
    .in_task_id           (in_task_id),
    .in_requester_priority(in_requester_priority),
    .in_owner_priority    (in_owner_priority),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_created_index    (out_created_index),
    .out_wake_valid       (out_wake_valid),
    .out_wake_task        (out_wake_task),
    .out_restore_priority (out_restore_priority)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        sb.check_result({out_status, out_created_index, out_wake_valid, out_wake_task,
                         out_restore_priority});
      end else if (out_valid !== 1'b0) begin
        $error("out_valid unknown after reset");
        sb.errors++;
      end
    end
  end

  // Optionally idle, then hold the request until its transfer and record it.
  task automatic send_request(input logic [REQ_W-1:0] req, input int m, input int tid,
                              input int rprio, input int oprio);
    if (!steady && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_req_type           <= req;
    in_mutex_index        <= m[IDX_IN_W-1:0];
    in_task_id            <= tid[TASK_W-1:0];
    in_requester_priority <= rprio[PRIO_W-1:0];
    in_owner_priority     <= oprio[PRIO_W-1:0];
    start                 <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.record_request(req, m[IDX_IN_W-1:0], tid[TASK_W-1:0], rprio[PRIO_W-1:0],
                      oprio[PRIO_W-1:0]);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_outcomes.size() != 0);
  endtask

  function automatic int live_entry();
    int picks [$];
    int i;
    for (i = 0; i < NUM_MUTEXES; i++)
      if (sb.in_use[i]) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  function automatic int rand_prio();
    return $urandom_range(0, 255);
  endfunction

  // Release until nobody holds the entry; waiters take over one by one.
  task automatic release_all(input int m);
    while (sb.hold_count[m] != 0)
      send_request(REQ_RELEASE, m, sb.owner[m], rand_prio(), rand_prio());
  endtask

  task automatic queue_burst(input int m);
    int tid;
    if (sb.hold_count[m] == 0)
      send_request(REQ_ACQUIRE, m, $urandom_range(0, 15), rand_prio(), rand_prio());
    // one more than the queue holds, so the last ones fault
    repeat (NUM_TASKS + 1) begin
      tid = $urandom_range(0, 15);
      if (tid == sb.owner[m]) tid = (tid + 1) % NUM_TASKS;
      send_request(REQ_ACQUIRE, m, tid, rand_prio(), rand_prio());
    end
    release_all(m);
  endtask

  task automatic recursion_burst(input int m, input int tid);
    if (sb.hold_count[m] == 0)
      send_request(REQ_ACQUIRE, m, tid, rand_prio(), rand_prio());
    while (sb.hold_count[m] != CNT_MAX)
      send_request(REQ_ACQUIRE, m, sb.owner[m], rand_prio(), rand_prio());
    // count is saturated: these overflow
    repeat (2) send_request(REQ_ACQUIRE, m, sb.owner[m], rand_prio(), rand_prio());
    release_all(m);
  endtask

  task automatic directed_requests();
    send_request(REQ_CREATE, 9, 2, 0, 0);
    send_request(REQ_ACQUIRE, 5, 1, 0, 0);
    send_request(REQ_RELEASE, 5, 1, 0, 0);
    send_request(REQ_DESTROY, 5, 1, 0, 0);
    send_request(REQ_ACQUIRE, 0, 3, 0, 255);
    send_request(REQ_ACQUIRE, 0, 3, 255, 0);
    send_request(REQ_ACQUIRE, 0, 7, 10, 20);
    send_request(REQ_ACQUIRE, 0, 9, 200, 200);
    send_request(REQ_ACQUIRE, 0, 9, 255, 0);
    send_request(REQ_RELEASE, 0, 7, 0, 0);
    send_request(REQ_DESTROY, 0, 3, 0, 0);
    send_request(REQ_RELEASE, 0, 3, 0, 0);
    send_request(REQ_RELEASE, 0, 3, 0, 0);
    send_request(REQ_RELEASE, 0, 7, 0, 0);
    send_request(REQ_RELEASE, 0, 9, 0, 0);
    send_request(REQ_RELEASE, 0, 9, 0, 0);
    send_request(REQ_RELEASE, 0, 9, 0, 0);
    send_request(REQ_DESTROY, 0, 9, 0, 0);
    send_request(REQ_CREATE, 15, 15, 255, 255);
    send_request(REQ_ACQUIRE, 0, 15, 0, 0);
    send_request(REQ_ACQUIRE, 0, 0, 0, 1);
    send_request(REQ_RELEASE, 0, 15, 255, 255);
    send_request(REQ_RELEASE, 0, 0, 255, 255);
  endtask

  task automatic random_request();
    int r;
    int m;
    int tid;
    r = $urandom_range(0, 99);
    m = live_entry();
    if (r < 15) begin
      send_request(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                   $urandom_range(0, 15), rand_prio(), rand_prio());
    end else if (r < 25 || m < 0) begin
      send_request(REQ_CREATE, $urandom_range(0, 15), $urandom_range(0, 15),
                   rand_prio(), rand_prio());
    end else if (r < 55) begin
      tid = (sb.hold_count[m] != 0 && $urandom_range(0, 1)) ? sb.owner[m]
                                                           : $urandom_range(0, 15);
      send_request(REQ_ACQUIRE, m, tid, rand_prio(), rand_prio());
    end else if (r < 80) begin
      tid = ($urandom_range(0, 99) < 85) ? sb.owner[m] : $urandom_range(0, 15);
      send_request(REQ_RELEASE, m, tid, rand_prio(), rand_prio());
    end else if (r < 90) begin
      send_request(REQ_DESTROY, m, $urandom_range(0, 15), rand_prio(), rand_prio());
    end else if (r < 97) begin
      send_request(REQ_ACQUIRE, m, $urandom_range(0, 15), rand_prio(), rand_prio());
    end else if (r < 99 || $urandom_range(0, 3) != 0) begin
      queue_burst(m);
    end else begin
      recursion_burst(m, $urandom_range(0, 15));
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_requests();
    drain_results();

    // fill the table past full, then saturate and flood individual entries
    repeat (NUM_MUTEXES + 1)
      send_request(REQ_CREATE, $urandom_range(0, 15), $urandom_range(0, 15),
                   rand_prio(), rand_prio());
    recursion_burst(NUM_MUTEXES - 1, NUM_TASKS - 1);
    queue_burst($urandom_range(0, NUM_MUTEXES - 1));

    while (items_sent < TARGET_ITEMS) begin
      steady = (items_sent >= 500 && items_sent < 750);
      if ($urandom_range(0, 199) == 0) drain_results();
      random_request();
    end
    steady = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests, %0d results checked, %0d hand-offs to waiters",
             items_sent, sb.checked, sb.wakes);
    $display("  granted %0d, queued %0d, queued with inheritance %0d, faults %0d, table full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_FIFO], sb.status_seen[ST_INHERIT],
             sb.status_seen[ST_FAULT], sb.status_seen[ST_NOFREE]);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $error("run did not finish in time; %0d results still outstanding",
           sb.pending_outcomes.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
